// ----- hw/rtl/tshd_pkg.sv -----
// shared types, codes and reset values for the sensor health debounce block
package tshd_pkg;

   // field widths
   localparam int unsigned StatusW = 3;
   localparam int unsigned TempW   = 12;
   localparam int unsigned CountW  = 8;
   localparam int unsigned TransW  = 2;
   localparam int unsigned HealthW = 2;
   localparam int unsigned CsrIdxW = 8;
   localparam int unsigned CsrDatW = 12;

   // read status codes
   localparam logic [StatusW-1:0] ST_OK       = 3'd0;
   localparam logic [StatusW-1:0] ST_NO_RESP  = 3'd1;
   localparam logic [StatusW-1:0] ST_POWER_ON = 3'd2;

   // transition codes
   localparam logic [TransW-1:0] TR_NONE      = 2'd0;
   localparam logic [TransW-1:0] TR_BECAME_OK = 2'd1;
   localparam logic [TransW-1:0] TR_RECOVERED = 2'd2;
   localparam logic [TransW-1:0] TR_FAULTED   = 2'd3;

   // health codes as seen on the result beat
   localparam logic [HealthW-1:0] HC_UNKNOWN = 2'd0;
   localparam logic [HealthW-1:0] HC_OK      = 2'd1;
   localparam logic [HealthW-1:0] HC_FAULT   = 2'd2;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_GOOD_NEEDED   = 8'd0;
   localparam logic [CsrIdxW-1:0] REG_BAD_NEEDED    = 8'd1;
   localparam logic [CsrIdxW-1:0] REG_POWER_ON_TEMP = 8'd2;
   localparam logic [CsrIdxW-1:0] REG_POWER_ON_JUMP = 8'd3;

   // register reset values
   localparam logic [CountW-1:0]       RST_GOOD_NEEDED   = 8'd3;
   localparam logic [CountW-1:0]       RST_BAD_NEEDED    = 8'd3;
   localparam logic signed [TempW-1:0] RST_POWER_ON_TEMP = 12'sd1360;
   localparam logic [TempW-1:0]        RST_POWER_ON_JUMP = 12'd80;

   localparam logic [CountW-1:0] RUN_MAX = '1;

   // health machine, one-hot
   typedef enum logic [2:0] {
      HS_UNKNOWN = 3'b001,
      HS_OK      = 3'b010,
      HS_FAULT   = 3'b100
   } health_type;

   typedef struct packed {
      logic [CountW-1:0]       good_needed;
      logic [CountW-1:0]       bad_needed;
      logic signed [TempW-1:0] power_on_temp;
      logic [TempW-1:0]        power_on_jump;
   } cfg_type;

   typedef struct packed {
      logic [TransW-1:0]       transition;
      logic [HealthW-1:0]      health;
      logic                    value_valid;
      logic signed [TempW-1:0] good_value;
      logic [StatusW-1:0]      last_error;
   } result_type;

   function automatic logic [HealthW-1:0] health_code(input health_type hs);
      logic [HealthW-1:0] code;
      case (hs)
         HS_UNKNOWN: code = HC_UNKNOWN;
         HS_OK:      code = HC_OK;
         HS_FAULT:   code = HC_FAULT;
         default:    code = HC_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

// ----- hw/rtl/tshd_intf.sv -----
// handshake channel interfaces: sample input, result output, register writes
interface tshd_req_if import tshd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [StatusW-1:0]      read_status;
   logic signed [TempW-1:0] temperature;

   modport source (output valid, read_status, temperature, input ready);
   modport sink   (input valid, read_status, temperature, output ready);
endinterface

interface tshd_rsp_if import tshd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TransW-1:0]       transition;
   logic [HealthW-1:0]      health;
   logic                    value_valid;
   logic signed [TempW-1:0] good_value;
   logic [StatusW-1:0]      last_error;

   modport source (output valid, transition, health, value_valid, good_value, last_error,
                   input ready);
   modport sink   (input valid, transition, health, value_valid, good_value, last_error,
                   output ready);
endinterface

interface tshd_csr_if import tshd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic [CsrDatW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/tshd_csr.sv -----
// configuration register file, written one beat at a time
module tshd_csr import tshd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   tshd_csr_if.sink       csr_if,
   output cfg_type        cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid && csr_if.ready;

   // decode the register index; other indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_if.index)
            REG_GOOD_NEEDED:   cfg_in.good_needed   = csr_if.data[CountW-1:0];
            REG_BAD_NEEDED:    cfg_in.bad_needed    = csr_if.data[CountW-1:0];
            REG_POWER_ON_TEMP: cfg_in.power_on_temp = signed'(csr_if.data[TempW-1:0]);
            REG_POWER_ON_JUMP: cfg_in.power_on_jump = csr_if.data[TempW-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.good_needed   <= RST_GOOD_NEEDED;
         cfg_ff.bad_needed    <= RST_BAD_NEEDED;
         cfg_ff.power_on_temp <= RST_POWER_ON_TEMP;
         cfg_ff.power_on_jump <= RST_POWER_ON_JUMP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/tshd_core.sv -----
// sample classification, run counters and health state machine
module tshd_core import tshd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [StatusW-1:0]      status,
   input  logic signed [TempW-1:0] temp,
   input  cfg_type                 cfg,
   output result_type              result
);

   health_type              health_ff, health_in;
   logic [CountW-1:0]       good_run_ff, good_run_in;
   logic [CountW-1:0]       bad_run_ff, bad_run_in;
   logic                    seen_good_ff, seen_good_in;
   logic signed [TempW-1:0] last_good_ff, last_good_in;
   logic                    prev_bad_ff, prev_bad_in;
   logic [StatusW-1:0]      last_bad_ff, last_bad_in;

   logic                    at_power_on;
   logic signed [TempW:0]   diff;
   logic [TempW:0]          jump_mag;
   logic                    too_far;
   logic                    is_good;
   logic [CountW-1:0]       good_inc, bad_inc;
   logic [TransW-1:0]       trans;

   // suspect power-on reading check
   always_comb begin
      at_power_on = (status == ST_OK) && (temp == cfg.power_on_temp);
      diff        = {temp[TempW-1], temp} - {last_good_ff[TempW-1], last_good_ff};
      jump_mag    = diff[TempW] ? unsigned'(-diff) : unsigned'(diff);
      too_far     = jump_mag > {1'b0, cfg.power_on_jump};
      is_good     = (status == ST_OK) &&
                    !(at_power_on && (!seen_good_ff || prev_bad_ff || too_far));
   end

   // saturating run increments
   assign good_inc = (good_run_ff == RUN_MAX) ? RUN_MAX : good_run_ff + CountW'(1);
   assign bad_inc  = (bad_run_ff == RUN_MAX) ? RUN_MAX : bad_run_ff + CountW'(1);

   // next state and transition
   always_comb begin
      health_in    = health_ff;
      good_run_in  = good_run_ff;
      bad_run_in   = bad_run_ff;
      seen_good_in = seen_good_ff;
      last_good_in = last_good_ff;
      prev_bad_in  = prev_bad_ff;
      last_bad_in  = last_bad_ff;
      trans        = TR_NONE;
      if (is_good) begin
         bad_run_in   = '0;
         good_run_in  = good_inc;
         prev_bad_in  = 1'b0;
         last_good_in = temp;
         seen_good_in = 1'b1;
         if (health_ff != HS_OK && good_inc >= cfg.good_needed) begin
            trans     = (health_ff == HS_UNKNOWN) ? TR_BECAME_OK : TR_RECOVERED;
            health_in = HS_OK;
         end
      end else begin
         good_run_in = '0;
         bad_run_in  = bad_inc;
         prev_bad_in = 1'b1;
         last_bad_in = (status == ST_OK) ? ST_POWER_ON : status;
         if (health_ff != HS_FAULT && bad_inc >= cfg.bad_needed) begin
            trans     = TR_FAULTED;
            health_in = HS_FAULT;
         end
      end
   end

   // result fields reflect the state after this sample
   always_comb begin
      result.transition  = trans;
      result.health      = health_code(health_in);
      result.value_valid = (health_in == HS_OK);
      result.good_value  = last_good_in;
      result.last_error  = last_bad_in;
   end

   // state update on each processed sample
   always_ff @(posedge clock) begin
      if (reset) begin
         health_ff    <= HS_UNKNOWN;
         good_run_ff  <= '0;
         bad_run_ff   <= '0;
         seen_good_ff <= 1'b0;
         last_good_ff <= '0;
         prev_bad_ff  <= 1'b1;
         last_bad_ff  <= ST_NO_RESP;
      end else if (advance) begin
         health_ff    <= health_in;
         good_run_ff  <= good_run_in;
         bad_run_ff   <= bad_run_in;
         seen_good_ff <= seen_good_in;
         last_good_ff <= last_good_in;
         prev_bad_ff  <= prev_bad_in;
         last_bad_ff  <= last_bad_in;
      end
   end

endmodule

// ----- hw/rtl/temp_sensor_health_debounce_unit.sv -----
// top level of the temperature sensor health debounce block
//
//   channel   dir  beat carries                                          flow
//   req_if    in   read_status, temperature                              valid/ready
//   rsp_if    out  transition, health, value_valid, good_value,          valid/ready
//                  last_error
//   csr_if    in   index, data                                           valid/ready
//
// one sample per cycle sustained while rsp_if is ready; a sample goes from req_if
// through the input register and the classify and update logic into the result
// register. reset is synchronous and returns the valid flags, config registers
// and health machine to their power-up values. a stall on rsp_if holds the
// result, lets one more sample wait in the input register, then drops req ready.
module temp_sensor_health_debounce_unit import tshd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tshd_req_if.sink   req_if,
   tshd_rsp_if.source rsp_if,
   tshd_csr_if.sink   csr_if
);

   cfg_type                 cfg;
   result_type              result;
   result_type              result_ff;
   logic                    in_vld_ff;
   logic [StatusW-1:0]      in_status_ff;
   logic signed [TempW-1:0] in_temp_ff;
   logic                    out_vld_ff;
   logic                    advance;
   logic                    req_beat;

   tshd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   // pipeline flow control
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_if.ready);
   assign req_if.ready = !in_vld_ff || advance;
   assign req_beat     = req_if.valid && req_if.ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_status_ff <= req_if.read_status;
         in_temp_ff   <= req_if.temperature;
      end
   end

   tshd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .status  (in_status_ff),
      .temp    (in_temp_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid       = out_vld_ff;
   assign rsp_if.transition  = result_ff.transition;
   assign rsp_if.health      = result_ff.health;
   assign rsp_if.value_valid = result_ff.value_valid;
   assign rsp_if.good_value  = result_ff.good_value;
   assign rsp_if.last_error  = result_ff.last_error;

endmodule
